[hdl/per_channel_min_max_mean_stats_top_macros.svh]
// Assertion macros shared by the statistics block RTL.
// Needs clk and rst_n in the scope of every use.
`ifndef PER_CHANNEL_MIN_MAX_MEAN_STATS_TOP_MACROS_SVH
`define PER_CHANNEL_MIN_MAX_MEAN_STATS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PCMMS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcmms: implication check failed");
`define PCMMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcmms: next-cycle check failed");
`else
`define PCMMS_ASSERT_IMPL(lbl, ante, cons)
`define PCMMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/pcmms_pkg.sv]
// Package for the per-channel statistics block: widths, item kinds,
// queue item, table entry and result types. No dependencies.
package pcmms_pkg;

  localparam int NUM_IDS = 128;
  localparam int ADDR_W  = $clog2(NUM_IDS);

  localparam int ID_W   = 7;
  localparam int TIME_W = 17;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 16;
  localparam int SUM_W  = 32;
  localparam int STEP_W = $clog2(SUM_W);

  localparam int IN_FIELDS_W = ID_W + TIME_W + VAL_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ID_W + 3 * VAL_W + 2 * TIME_W + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QPTR_W:0]   qcnt_t;

  localparam cnt_t COUNT_MAX = '1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_SAMPLE      = 2'd0;
  localparam kind_t KIND_REPORT      = 2'd1;
  localparam kind_t KIND_REPORT_NULL = 2'd2;

  typedef struct packed {
    kind_t kind;
    addr_t addr;
    id_t   id;
    time_t stamp;
    val_t  value;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    val_t  max_v;
    val_t  min_v;
    sum_t  sum;
    cnt_t  cnt;
    time_t max_t;
    time_t min_t;
  } entry_t;

  typedef struct packed {
    id_t   id;
    val_t  max_v;
    val_t  min_v;
    val_t  mean;
    time_t max_t;
    time_t min_t;
    cnt_t  cnt;
    logic  empty;
  } res_t;

endpackage

[hdl/pcmms_front.sv]
// Front end: unpacks input items, classifies them and pushes them into the queue.
// Depends on pcmms_pkg.
module pcmms_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pcmms_pkg::IN_TDATA_W-1:0] in_tdata,   // sensor_id, sample_time, sample_value
  input  logic                             in_tuser,   // cmd
  input  pcmms_pkg::q_stat_t               q_stat,
  input  logic                             clear_busy,
  output logic                             q_push,
  output pcmms_pkg::q_item_t               q_item
);

  pcmms_pkg::id_t   id;
  pcmms_pkg::time_t stamp;
  pcmms_pkg::val_t  value;
  logic             in_range;
  logic             accept;

  assign id    = in_tdata[pcmms_pkg::ID_W-1:0];
  assign stamp = in_tdata[pcmms_pkg::ID_W +: pcmms_pkg::TIME_W];
  assign value = in_tdata[pcmms_pkg::ID_W + pcmms_pkg::TIME_W +: pcmms_pkg::VAL_W];

  assign in_range  = (32'(id) < 32'(pcmms_pkg::NUM_IDS));
  assign in_tready = !q_stat.full && !clear_busy;
  assign accept    = in_tvalid && in_tready;

  // out-of-table samples are dropped here
  assign q_push = accept && (in_tuser == pcmms_pkg::CMD_REPORT || in_range);

  always_comb begin
    q_item.addr  = pcmms_pkg::addr_t'(id);
    q_item.id    = id;
    q_item.stamp = stamp;
    q_item.value = value;
    if (in_tuser == pcmms_pkg::CMD_SAMPLE) begin
      q_item.kind = pcmms_pkg::KIND_SAMPLE;
    end else if (in_range) begin
      q_item.kind = pcmms_pkg::KIND_REPORT;
    end else begin
      q_item.kind = pcmms_pkg::KIND_REPORT_NULL;
    end
  end

endmodule

[hdl/pcmms_fifo.sv]
// Short item queue between front end and table engine.
// Depends on pcmms_pkg.
module pcmms_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pcmms_pkg::q_item_t push_item,
  input  logic               pop,
  output pcmms_pkg::q_item_t head,
  output pcmms_pkg::q_stat_t stat
);

  pcmms_pkg::q_item_t slot_r [pcmms_pkg::QUEUE_DEPTH];
  pcmms_pkg::qptr_t   wr_ptr_r, wr_ptr_nxt;
  pcmms_pkg::qptr_t   rd_ptr_r, rd_ptr_nxt;
  pcmms_pkg::qcnt_t   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == pcmms_pkg::qcnt_t'(pcmms_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + pcmms_pkg::qptr_t'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + pcmms_pkg::qptr_t'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + pcmms_pkg::qcnt_t'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - pcmms_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hdl/pcmms_div.sv]
// Restoring divider, one quotient bit per cycle: sum / count for the mean.
// Depends on pcmms_pkg.
module pcmms_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  pcmms_pkg::sum_t dividend,
  input  pcmms_pkg::cnt_t divisor,
  output logic            done,
  output pcmms_pkg::val_t quotient
);

  pcmms_pkg::sum_t          quo_r, quo_nxt;
  pcmms_pkg::cnt_t          rem_r, rem_nxt;
  pcmms_pkg::cnt_t          div_r;
  pcmms_pkg::step_t         step_r, step_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [pcmms_pkg::CNT_W:0] rem_sh, diff;
  logic                     ge;

  assign rem_sh = {rem_r, quo_r[pcmms_pkg::SUM_W-1]};
  assign diff   = rem_sh - {1'b0, div_r};
  assign ge     = (rem_sh >= {1'b0, div_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[pcmms_pkg::SUM_W-2:0], ge};
      rem_nxt  = ge ? diff[pcmms_pkg::CNT_W-1:0] : rem_sh[pcmms_pkg::CNT_W-1:0];
      step_nxt = step_r + pcmms_pkg::step_t'(1);
      if (step_r == pcmms_pkg::step_t'(pcmms_pkg::SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[pcmms_pkg::VAL_W-1:0];

endmodule

[hdl/pcmms_back.sv]
// Table engine: statistics memory, read-modify-write of samples, reports,
// output register and the clearing pass after reset.
// Depends on pcmms_pkg, pcmms_div and the assertion macro header.
`include "per_channel_min_max_mean_stats_top_macros.svh"
module pcmms_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pcmms_pkg::q_item_t q_head,
  input  pcmms_pkg::q_stat_t q_stat,
  output logic               q_pop,
  output logic               clear_busy,
  output logic               res_valid,
  input  logic               res_ready,
  output pcmms_pkg::res_t    res
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  pcmms_pkg::entry_t  mem [pcmms_pkg::NUM_IDS];
  pcmms_pkg::entry_t  rd_data_r;
  pcmms_pkg::entry_t  wr_data, upd;
  pcmms_pkg::addr_t   wr_addr;
  logic               wr_en;

  logic [1:0]         state_r, state_nxt;
  pcmms_pkg::addr_t   clr_addr_r, clr_addr_nxt;
  pcmms_pkg::q_item_t cur_r;
  logic               out_valid_r, out_valid_nxt;
  pcmms_pkg::res_t    out_r, out_nxt;

  logic               div_start, div_done;
  pcmms_pkg::val_t    div_quo;

  pcmms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r.sum),
    .divisor  (rd_data_r.cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign clear_busy = (state_r == ST_CLEAR);
  assign q_pop = (state_r == ST_IDLE) && !q_stat.empty &&
                 (q_head.kind == pcmms_pkg::KIND_SAMPLE || !out_valid_r);

  always_comb begin
    upd = rd_data_r;
    if (rd_data_r.cnt == '0) begin
      upd.max_v = cur_r.value;
      upd.min_v = cur_r.value;
      upd.max_t = cur_r.stamp;
      upd.min_t = cur_r.stamp;
    end else begin
      if (cur_r.value > rd_data_r.max_v) begin
        upd.max_v = cur_r.value;
        upd.max_t = cur_r.stamp;
      end
      if (cur_r.value < rd_data_r.min_v) begin
        upd.min_v = cur_r.value;
        upd.min_t = cur_r.stamp;
      end
    end
    upd.sum = rd_data_r.sum + pcmms_pkg::sum_t'(cur_r.value);
    upd.cnt = rd_data_r.cnt + pcmms_pkg::cnt_t'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = cur_r.addr;
    wr_data       = upd;
    div_start     = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + pcmms_pkg::addr_t'(1);
        if (clr_addr_r == pcmms_pkg::addr_t'(pcmms_pkg::NUM_IDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt     = ST_IDLE;
        out_nxt       = '0;
        out_nxt.id    = cur_r.id;
        out_nxt.empty = 1'b1;
        case (cur_r.kind)
          pcmms_pkg::KIND_SAMPLE: begin
            out_nxt = out_r;
            wr_en   = (rd_data_r.cnt != pcmms_pkg::COUNT_MAX);
          end
          pcmms_pkg::KIND_REPORT: begin
            if (rd_data_r.cnt == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              out_nxt.max_v = rd_data_r.max_v;
              out_nxt.min_v = rd_data_r.min_v;
              out_nxt.max_t = rd_data_r.max_t;
              out_nxt.min_t = rd_data_r.min_t;
              out_nxt.cnt   = rd_data_r.cnt;
              out_nxt.empty = 1'b0;
              div_start     = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          out_nxt.mean  = div_quo;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_data_r <= mem[q_head.addr];
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  `PCMMS_ASSERT_IMPL(a_wr_only_clear_or_rd, wr_en, state_r == ST_CLEAR || state_r == ST_RD)
  `PCMMS_ASSERT_IMPL(a_div_with_free_out, state_r == ST_DIV, !out_valid_r)
  `PCMMS_ASSERT_IMPL(a_div_done_in_div, div_done, state_r == ST_DIV)
  `PCMMS_ASSERT_NEXT(a_pop_then_read, q_pop, state_r == ST_RD)

endmodule

[hdl/per_channel_min_max_mean_stats_top.sv]
// Per-sensor running min/max/mean statistics, top level.
// Uses pcmms_pkg, pcmms_front, pcmms_fifo and pcmms_back.
// A sample item is a memory read, then a write of the updated entry unless its
// count has saturated; a report of an empty or out-of-table id is answered from
// the read state, one with data also runs the 32-step bit-serial divider for
// the mean. A 4-deep queue in front of the engine, until full, keeps accepting
// items while it works or a result waits in the output register. After reset
// the NUM_IDS (128) entries clear one a cycle, with in_tready low.
module per_channel_min_max_mean_stats_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pcmms_pkg::IN_TDATA_W-1:0]  in_tdata,  // sensor_id, sample_time, sample_value
  input  logic                              in_tuser,  // cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // report_id, max_value, min_value, mean_value, max_time, min_time, sample_count
  output logic [pcmms_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tuser  // is_empty
);

  pcmms_pkg::q_stat_t q_stat;
  pcmms_pkg::q_item_t q_item, q_head;
  logic               q_push, q_pop, clear_busy;
  pcmms_pkg::res_t    res;

  pcmms_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_stat     (q_stat),
    .clear_busy (clear_busy),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  pcmms_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  pcmms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {{pcmms_pkg::OUT_PAD_W{1'b0}}, res.cnt, res.min_t, res.max_t,
                      res.mean, res.min_v, res.max_v, res.id};
  assign out_tuser = res.empty;

endmodule
